// ===== sv/adv_pkg.sv =====
// Shared types, constants and result builders for the archive directory validator.
// Depends on nothing; every other file of the block imports it.
package adv_pkg;

  // Parse phase of the current archive.
  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_ENTRY  = 2'd2
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Reject codes.
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_SMALL    = 4'd1;
  localparam logic [3:0] ERR_MAGIC    = 4'd2;
  localparam logic [3:0] ERR_VERSION  = 4'd3;
  localparam logic [3:0] ERR_INDEXOFF = 4'd4;
  localparam logic [3:0] ERR_COUNT    = 4'd5;
  localparam logic [3:0] ERR_DIRFIT   = 4'd6;
  localparam logic [3:0] ERR_OFFSET   = 4'd7;
  localparam logic [3:0] ERR_NEGSIZE  = 4'd8;
  localparam logic [3:0] ERR_RANGE    = 4'd9;
  localparam logic [3:0] ERR_NONAME   = 4'd10;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILE_SIZE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRIES = 1'd1;
  localparam logic [19:0] MAX_ENTRIES_RESET = 20'd1000000;

  // Archive format constants.
  localparam logic [31:0] GOB_MAGIC     = 32'h2042_4F47;
  localparam logic [31:0] GOB_VERSION   = 32'd20;
  localparam logic [31:0] GOB_INDEX_OFF = 32'h0000_000C;
  localparam logic [31:0] HDR_LEN       = 32'h0000_0010;
  localparam logic [31:0] MIN_FILE_SIZE = 32'h0000_0098;

  // Byte positions within the header and within a directory entry.
  localparam logic [7:0] POS_MAGIC_END   = 8'd3;
  localparam logic [7:0] POS_VERSION_END = 8'd7;
  localparam logic [7:0] POS_INDEX_END   = 8'd11;
  localparam logic [7:0] POS_HDR_LAST    = 8'd15;
  localparam logic [7:0] POS_OFFSET_END  = 8'd3;
  localparam logic [7:0] POS_SIZE_END    = 8'd7;
  localparam logic [7:0] POS_NAME        = 8'd8;
  localparam logic [7:0] POS_ENT_LAST    = 8'd135;

  // Depth of the result queue.
  localparam int unsigned RES_FIFO_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] entry_index;
    logic [30:0] entry_offset;
    logic [30:0] entry_size;
    logic [31:0] archive_end;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  // Write strobes from the parser into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } res_wr_t;

  function automatic res_t make_reject(input logic [3:0] code);
    res_t r;
    r            = '0;
    r.kind       = KIND_REJECT;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic res_t make_record(input logic [19:0] idx, input logic [30:0] off,
                                       input logic [30:0] sz);
    res_t r;
    r              = '0;
    r.kind         = KIND_ENTRY;
    r.entry_index  = idx;
    r.entry_offset = off;
    r.entry_size   = sz;
    return r;
  endfunction

  function automatic res_t make_accept(input logic [31:0] end_pos);
    res_t r;
    r             = '0;
    r.kind        = KIND_ACCEPT;
    r.archive_end = end_pos;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/adv_parser.sv =====
// Byte parser: input register, header and directory entry checks, result generation.
// Depends on adv_pkg.
module adv_parser
  import adv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        restart,
  input  logic [31:0] file_size,
  input  logic [19:0] max_entries,
  input  logic        room,
  output res_wr_t     wr,
  output res_t        res0,
  output res_t        res1
);

  // Input register stage.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_restart;
  logic       go;

  // Parse state.
  phase_t      phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [19:0] entry_count, entry_count_next;
  logic [19:0] current_entry, current_entry_next;
  logic [31:0] held_offset, held_offset_next;
  logic [31:0] held_size, held_size_next;
  logic [27:0] directory_end, directory_end_next;
  logic [32:0] running_end, running_end_next;

  // Working values for the current byte.
  phase_t      ph_cur;
  logic [7:0]  pos_cur;
  logic [31:0] wa_shift;
  logic        small_file;
  logic        count_bad;
  logic [27:0] dir_bytes;
  logic [27:0] dir_end;
  logic        dir_bad;
  logic        off_bad;
  logic [31:0] room_after_off;
  logic        range_bad;
  logic [32:0] member_end;
  logic [32:0] end_max;
  logic        last_entry;

  // A request moves in when the stage is empty or its byte is processed this cycle.
  assign go       = stage_valid && room;
  assign in_ready = !stage_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_byte    <= byte_value;
      stage_restart <= restart;
    end
  end

  // A restart byte sees a cleared parse in the header phase.
  assign ph_cur   = stage_restart ? PH_HEADER : phase;
  assign pos_cur  = stage_restart ? 8'd0 : byte_position;
  assign wa_shift = {stage_byte, (stage_restart ? 24'd0 : word_assembly[31:8])};

  assign small_file = file_size < MIN_FILE_SIZE;

  // Entry count checks; the directory size is count * 136 as a shift-add.
  assign count_bad = wa_shift[31] || (wa_shift == 32'd0) || (wa_shift > {12'd0, max_entries});
  assign dir_bytes = {1'b0, wa_shift[19:0], 7'd0} + {5'd0, wa_shift[19:0], 3'd0};
  assign dir_end   = dir_bytes + HDR_LEN[27:0];
  assign dir_bad   = (file_size >= HDR_LEN) && ({4'd0, dir_end} > file_size);

  // Entry checks on the first name byte.
  assign off_bad        = held_offset[31] || (held_offset < {4'd0, directory_end});
  assign room_after_off = file_size - held_offset;
  assign range_bad      = (held_offset > file_size) || (held_size > room_after_off);
  assign member_end     = {1'b0, held_offset} + {1'b0, held_size};
  assign end_max        = (member_end > running_end) ? member_end : running_end;
  assign last_entry     = ({1'b0, current_entry} + 21'd1) >= {1'b0, entry_count};

  // Next state and results for the byte in the stage.
  always_comb begin
    phase_next         = stage_restart ? PH_HEADER : phase;
    byte_position_next = pos_cur;
    word_assembly_next = stage_restart ? 32'd0 : word_assembly;
    entry_count_next   = stage_restart ? 20'd0 : entry_count;
    current_entry_next = stage_restart ? 20'd0 : current_entry;
    held_offset_next   = stage_restart ? 32'd0 : held_offset;
    held_size_next     = stage_restart ? 32'd0 : held_size;
    directory_end_next = stage_restart ? 28'd0 : directory_end;
    running_end_next   = stage_restart ? 33'd0 : running_end;
    wr                 = '0;
    res0               = '0;
    res1               = '0;

    if (stage_restart && small_file) begin
      res0       = make_reject(ERR_SMALL);
      wr.first   = 1'b1;
      phase_next = PH_DONE;
    end else if (ph_cur == PH_HEADER) begin
      word_assembly_next = wa_shift;
      byte_position_next = pos_cur + 8'd1;
      if (pos_cur == POS_MAGIC_END && wa_shift != GOB_MAGIC) begin
        res0       = make_reject(ERR_MAGIC);
        wr.first   = 1'b1;
        phase_next = PH_DONE;
      end else if (pos_cur == POS_VERSION_END && wa_shift != GOB_VERSION) begin
        res0       = make_reject(ERR_VERSION);
        wr.first   = 1'b1;
        phase_next = PH_DONE;
      end else if (pos_cur == POS_INDEX_END && wa_shift != GOB_INDEX_OFF) begin
        res0       = make_reject(ERR_INDEXOFF);
        wr.first   = 1'b1;
        phase_next = PH_DONE;
      end else if (pos_cur == POS_HDR_LAST) begin
        if (count_bad) begin
          res0       = make_reject(ERR_COUNT);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else if (dir_bad) begin
          res0       = make_reject(ERR_DIRFIT);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          entry_count_next   = wa_shift[19:0];
          directory_end_next = dir_end;
          running_end_next   = {5'd0, dir_end};
          current_entry_next = 20'd0;
          byte_position_next = 8'd0;
          phase_next         = PH_ENTRY;
        end
      end
    end else if (ph_cur == PH_ENTRY) begin
      word_assembly_next = wa_shift;
      if (pos_cur >= POS_ENT_LAST) begin
        byte_position_next = 8'd0;
        current_entry_next = current_entry + 20'd1;
      end else begin
        byte_position_next = pos_cur + 8'd1;
      end
      if (pos_cur == POS_OFFSET_END) begin
        held_offset_next = wa_shift;
      end else if (pos_cur == POS_SIZE_END) begin
        held_size_next = wa_shift;
      end else if (pos_cur == POS_NAME) begin
        if (off_bad) begin
          res0       = make_reject(ERR_OFFSET);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else if (held_size[31]) begin
          res0       = make_reject(ERR_NEGSIZE);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else if (range_bad) begin
          res0       = make_reject(ERR_RANGE);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else if (stage_byte == 8'd0) begin
          res0       = make_reject(ERR_NONAME);
          wr.first   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          res0             = make_record(current_entry, held_offset[30:0], held_size[30:0]);
          wr.first         = 1'b1;
          running_end_next = end_max;
          if (last_entry) begin
            res1       = make_accept(end_max[31:0]);
            wr.second  = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
    end

    // Nothing moves unless the byte is actually processed.
    if (!go) begin
      wr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      byte_position <= 8'd0;
      word_assembly <= 32'd0;
      entry_count   <= 20'd0;
      current_entry <= 20'd0;
      held_offset   <= 32'd0;
      held_size     <= 32'd0;
      directory_end <= 28'd0;
      running_end   <= 33'd0;
    end else if (go) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      word_assembly <= word_assembly_next;
      entry_count   <= entry_count_next;
      current_entry <= current_entry_next;
      held_offset   <= held_offset_next;
      held_size     <= held_size_next;
      directory_end <= directory_end_next;
      running_end   <= running_end_next;
    end
  end

endmodule

// ===== sv/adv_result_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per output request.
// Depends on adv_pkg; DEPTH must be a power of two of at least 2.
module adv_result_fifo
  import adv_pkg::*;
#(
  parameter int unsigned DEPTH = RES_FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  res_wr_t wr,
  input  res_t    din0,
  input  res_t    din1,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    dout
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  // Room for two more results, whatever leaves this cycle.
  assign room      = count <= CNT_W'(DEPTH - 2);
  assign out_valid = count != '0;
  assign dout      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = CNT_W'(wr.first) + CNT_W'(wr.second);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

  // Storage writes; the second result goes right behind the first.
  always_ff @(posedge clk) begin
    if (wr.first) begin
      mem[wr_ptr] <= din0;
    end
    if (wr.second) begin
      mem[wr_ptr + PTR_W'(1)] <= din1;
    end
  end

endmodule

// ===== sv/archive_directory_validator.sv =====
// Top level of the archive directory validator: configuration registers, parser, result queue.
// Depends on adv_pkg, adv_parser and adv_result_fifo.
//
//   Channel  Handshake                Payload
//   input    in_valid / in_ready      byte_value, restart
//   output   out_valid / out_ready    kind, entry_index, entry_offset, entry_size,
//                                     archive_end, error_code, last
//   config   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One byte is taken per cycle; it is checked while it sits in the input register,
// and its results are then written into the queue. A byte makes zero, one or two
// results; the queue drains one result per cycle while out_ready is high. The input
// side stalls only while the queue lacks room for two results. Reset clears the
// parse to the finished phase and empties the queue; cfg_ready is always high.
module archive_directory_validator
  import adv_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = RES_FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             byte_value,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             kind,
  output logic [19:0]            entry_index,
  output logic [30:0]            entry_offset,
  output logic [30:0]            entry_size,
  output logic [31:0]            archive_end,
  output logic [3:0]             error_code,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [31:0] file_size;
  logic [19:0] max_entries;
  logic        room;
  res_wr_t     wr;
  res_t        res0;
  res_t        res1;
  res_t        head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size   <= 32'd0;
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILE_SIZE:   file_size   <= cfg_data;
        CFG_MAX_ENTRIES: max_entries <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  adv_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_value  (byte_value),
    .restart     (restart),
    .file_size   (file_size),
    .max_entries (max_entries),
    .room        (room),
    .wr          (wr),
    .res0        (res0),
    .res1        (res1)
  );

  adv_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (head)
  );

  // Result fields from the queue head.
  assign kind         = head.kind;
  assign entry_index  = head.entry_index;
  assign entry_offset = head.entry_offset;
  assign entry_size   = head.entry_size;
  assign archive_end  = head.archive_end;
  assign error_code   = head.error_code;
  assign last         = head.last;

endmodule

// ===== tb/adv_directory_checker.sv =====
`timescale 1ns / 100ps
// Checker for the archive directory validator: tracks configuration writes, predicts
// the records, accepts and rejects that each accepted request causes, and compares them.
// Depends on adv_pkg for the result layout, codes and format constants.
module adv_directory_checker
  import adv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             byte_value,
  input  logic                   restart,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             kind,
  input  logic [19:0]            entry_index,
  input  logic [30:0]            entry_offset,
  input  logic [30:0]            entry_size,
  input  logic [31:0]            archive_end,
  input  logic [3:0]             error_code,
  input  logic                   last,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int unsigned            mismatches,
  output int unsigned            pending_count,
  output int unsigned            results_seen
);

  localparam logic [63:0] ENTRY_BYTES = 64'd136;
  localparam int unsigned PRINT_CAP   = 200;

  // Shadow copy of the configuration registers.
  logic [31:0] size_reg;
  logic [19:0] entries_reg;

  // Shadow copy of the parser state.
  phase_t      parse_phase;
  logic [7:0]  pos;
  logic [31:0] shift_word;
  logic [19:0] dir_entries;
  logic [19:0] entry_no;
  logic [31:0] entry_off;
  logic [31:0] entry_len;
  logic [27:0] dir_limit;
  logic [32:0] far_end;

  // Results predicted but not yet seen on the output channel, oldest first.
  res_t awaited_results[$];

  task automatic log_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string label, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", label, got, want));
  endtask

  task automatic add_result(input logic [1:0] k, input logic [19:0] idx,
                            input logic [30:0] off, input logic [30:0] sz,
                            input logic [31:0] end_pos, input logic [3:0] code,
                            input logic lst);
    res_t r;
    r.kind         = k;
    r.entry_index  = idx;
    r.entry_offset = off;
    r.entry_size   = sz;
    r.archive_end  = end_pos;
    r.error_code   = code;
    r.last         = lst;
    awaited_results.push_back(r);
  endtask

  task automatic reject_archive(input logic [3:0] code);
    add_result(KIND_REJECT, '0, '0, '0, '0, code, 1'b1);
    parse_phase = PH_DONE;
  endtask

  task automatic clear_parse();
    pos         = '0;
    shift_word  = '0;
    dir_entries = '0;
    entry_no    = '0;
    entry_off   = '0;
    entry_len   = '0;
    dir_limit   = '0;
    far_end     = '0;
  endtask

  // Advance the shadow parser by one archive byte and queue what it emits.
  task automatic parse_byte(input logic [7:0] b, input logic rs);
    logic [63:0] dir_bytes;
    logic [32:0] member_end;
    if (rs) begin
      clear_parse();
      parse_phase = PH_HEADER;
      if (size_reg < MIN_FILE_SIZE) begin
        reject_archive(ERR_SMALL);
        return;
      end
    end
    if (parse_phase == PH_DONE) return;

    shift_word = {b, shift_word[31:8]};

    // Header: magic, version, index offset, then the entry count.
    if (parse_phase == PH_HEADER) begin
      if (pos == POS_MAGIC_END && shift_word != GOB_MAGIC) begin
        reject_archive(ERR_MAGIC);
        return;
      end
      if (pos == POS_VERSION_END && shift_word != GOB_VERSION) begin
        reject_archive(ERR_VERSION);
        return;
      end
      if (pos == POS_INDEX_END && shift_word != GOB_INDEX_OFF) begin
        reject_archive(ERR_INDEXOFF);
        return;
      end
      if (pos == POS_HDR_LAST) begin
        if (shift_word[31] || shift_word == '0 || shift_word > {12'd0, entries_reg}) begin
          reject_archive(ERR_COUNT);
          return;
        end
        dir_bytes = 64'(shift_word) * ENTRY_BYTES;
        if (dir_bytes > 64'(size_reg) - 64'(HDR_LEN)) begin
          reject_archive(ERR_DIRFIT);
          return;
        end
        dir_entries = shift_word[19:0];
        dir_limit   = 28'(64'(HDR_LEN) + dir_bytes);
        far_end     = {5'd0, dir_limit};
        entry_no    = '0;
        pos         = '0;
        parse_phase = PH_ENTRY;
        return;
      end
      pos++;
      return;
    end

    // Directory entry: offset, size, then all checks on the first name byte.
    if (pos == POS_OFFSET_END) begin
      entry_off = shift_word;
    end else if (pos == POS_SIZE_END) begin
      entry_len = shift_word;
    end else if (pos == POS_NAME) begin
      if (entry_off[31] || entry_off < {4'd0, dir_limit}) begin
        reject_archive(ERR_OFFSET);
        return;
      end
      if (entry_len[31]) begin
        reject_archive(ERR_NEGSIZE);
        return;
      end
      if (entry_off > size_reg || entry_len > size_reg - entry_off) begin
        reject_archive(ERR_RANGE);
        return;
      end
      if (b == 8'd0) begin
        reject_archive(ERR_NONAME);
        return;
      end
      add_result(KIND_ENTRY, entry_no, entry_off[30:0], entry_len[30:0], '0, ERR_NONE, 1'b0);
      member_end = {1'b0, entry_off} + {1'b0, entry_len};
      if (member_end > far_end) far_end = member_end;
      if ({1'b0, entry_no} + 21'd1 >= {1'b0, dir_entries}) begin
        add_result(KIND_ACCEPT, '0, '0, '0, far_end[31:0], ERR_NONE, 1'b1);
        parse_phase = PH_DONE;
        return;
      end
      pos++;
      return;
    end

    if (pos >= POS_ENT_LAST) begin
      pos = '0;
      entry_no++;
    end else begin
      pos++;
    end
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic compare_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      log_mismatch($sformatf("unexpected result of kind %0d", kind));
    end else begin
      want = awaited_results.pop_front();
      check_field("kind", 32'(kind), 32'(want.kind));
      check_field("entry_index", 32'(entry_index), 32'(want.entry_index));
      check_field("entry_offset", 32'(entry_offset), 32'(want.entry_offset));
      check_field("entry_size", 32'(entry_size), 32'(want.entry_size));
      check_field("archive_end", archive_end, want.archive_end);
      check_field("error_code", 32'(error_code), 32'(want.error_code));
      check_field("last", 32'(last), 32'(want.last));
    end
  endtask

  // Sample all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      size_reg    = '0;
      entries_reg = MAX_ENTRIES_RESET;
      parse_phase = PH_DONE;
      clear_parse();
      awaited_results.delete();
      mismatches    = 0;
      results_seen  <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FILE_SIZE) size_reg = cfg_data;
        else if (cfg_index == CFG_MAX_ENTRIES) entries_reg = cfg_data[19:0];
      end
      if (out_valid && out_ready) begin
        compare_result();
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready) parse_byte(byte_value, restart);
      pending_count <= awaited_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the archive directory validator testbench: builds archive byte streams,
// writes the registers, varies the flow control and prints the verdict.
// Depends on adv_pkg, archive_directory_validator and adv_directory_checker.
module tb;
  import adv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 8;

  // Kinds of damage applied to a generated archive.
  typedef enum int {
    DF_NONE, DF_MAGIC, DF_VERSION, DF_INDEX, DF_COUNT_ZERO, DF_COUNT_BIG, DF_COUNT_NEG,
    DF_DIRFIT, DF_OFF_NEG, DF_OFF_LOW, DF_SIZE_NEG, DF_RANGE, DF_NONAME, DF_TRUNC, DF_NOISE
  } defect_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [7:0]             byte_value = 8'd0;
  logic                   restart    = 1'b0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [1:0]             kind;
  logic [19:0]            entry_index;
  logic [30:0]            entry_offset;
  logic [30:0]            entry_size;
  logic [31:0]            archive_end;
  logic [3:0]             error_code;
  logic                   last;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_FILE_SIZE;
  logic [31:0]            cfg_data   = 32'd0;

  int unsigned mismatches;
  int unsigned pending_count;
  int unsigned results_seen;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 71;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  logic [31:0] cur_file_size   = 32'd0;
  logic [19:0] cur_max_entries = MAX_ENTRIES_RESET;

  // Archive under construction: {restart, byte} per request.
  logic [8:0] archive_bytes[$];

  archive_directory_validator i_dut (.*);

  adv_directory_checker i_checker (.*);

  always #5 clk = ~clk;

  // Receiver side stalls at random.
  always @(posedge clk) out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [31:0] pick(input longint unsigned lo, input longint unsigned hi);
    if (hi <= lo) return 32'(lo);
    case ($urandom_range(3, 0))
      0:       return 32'(lo);
      1:       return 32'(hi);
      default: return 32'(lo + ($urandom % (hi - lo + 1)));
    endcase
  endfunction

  function automatic logic [31:0] flip_mask();
    return $urandom_range(1, 0) ? (32'd1 << $urandom_range(31, 0)) : ($urandom | 32'd1);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic rs);
    archive_bytes.push_back({rs, b});
  endtask

  // Little-endian word; the very first byte of an archive carries the restart flag.
  task automatic push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) push_byte(w[8*k +: 8], archive_bytes.size() == 0);
  endtask

  // Build one archive for the current register settings, damaged as requested.
  task automatic build_archive(input defect_t defect);
    logic [31:0]     magic, ver, idx, cnt, off, sz;
    logic [7:0]      name0;
    longint unsigned maxfit, dir_end, lim, room;
    int unsigned     bad, n;
    archive_bytes.delete();
    if (defect == DF_NOISE) begin
      push_byte(8'($urandom_range(255, 0)), 1'b1);
      n = $urandom_range(40, 1);
      repeat (n) push_byte(8'($urandom_range(255, 0)), $urandom_range(15, 0) == 0);
      return;
    end

    // Mostly single-entry archives; a few longer directories.
    maxfit = (cur_file_size < 32'd16) ? 0 : (longint'(cur_file_size) - 16) / 136;
    n = $urandom_range(19, 0);
    cnt = (n < 17) ? 32'd1 : (n < 19) ? 32'd2 : 32'd3;
    if (cnt > cur_max_entries) cnt = cur_max_entries;
    if (cnt > maxfit) cnt = 32'(maxfit);
    magic = GOB_MAGIC;
    ver   = GOB_VERSION;
    idx   = GOB_INDEX_OFF;
    case (defect)
      DF_MAGIC:      magic ^= flip_mask();
      DF_VERSION:    ver ^= flip_mask();
      DF_INDEX:      idx ^= flip_mask();
      DF_COUNT_ZERO: cnt = 32'd0;
      DF_COUNT_BIG:  cnt = cur_max_entries + $urandom_range(3, 1);
      DF_COUNT_NEG:  cnt = 32'h8000_0000 | $urandom;
      DF_DIRFIT:     cnt = 32'(maxfit + 1);
      default: ;
    endcase
    push_word(magic);
    push_word(ver);
    push_word(idx);
    push_word(cnt);

    // A header that fails gets a few trailing bytes that must be ignored.
    if ((defect >= DF_MAGIC && defect <= DF_DIRFIT) || cnt == 0 ||
        cur_file_size < MIN_FILE_SIZE) begin
      repeat ($urandom_range(3, 0)) push_byte(8'($urandom_range(255, 0)), 1'b0);
      return;
    end

    dir_end = 16 + 136 * longint'(cnt);
    lim     = (cur_file_size < 32'h7FFF_FFFF) ? cur_file_size : 32'h7FFF_FFFF;
    bad     = $urandom_range(cnt - 1, 0);
    for (int i = 0; i < cnt; i++) begin
      off   = pick(dir_end, lim);
      room  = longint'(cur_file_size) - off;
      if (room > 32'h7FFF_FFFF) room = 32'h7FFF_FFFF;
      sz    = pick(0, room);
      name0 = 8'($urandom_range(255, 1));
      if (i == bad) begin
        case (defect)
          DF_OFF_NEG:  off = 32'h8000_0000 | $urandom;
          DF_OFF_LOW:  off = $urandom_range(32'(dir_end - 1), 0);
          DF_SIZE_NEG: sz = 32'h8000_0000 | $urandom;
          DF_RANGE: begin
            if (cur_file_size < 32'h7FFF_FFFF && $urandom_range(1, 0))
              off = $urandom_range(32'h7FFF_FFFF, cur_file_size + 1);
            else
              sz = 32'h7FFF_FFFF;
          end
          DF_NONAME:   name0 = 8'd0;
          default: ;
        endcase
      end
      push_word(off);
      push_word(sz);
      push_byte(name0, 1'b0);
      // The parse ends on the name byte of the last or the damaged entry.
      if (i == cnt - 1 || (i == bad && defect >= DF_OFF_NEG && defect <= DF_NONAME)) break;
      repeat (127) push_byte(8'($urandom_range(255, 0)), 1'b0);
    end
    repeat ($urandom_range(3, 0)) push_byte(8'($urandom_range(255, 0)), 1'b0);

    // Cut the stream short; the next restart drops the partial parse.
    if (defect == DF_TRUNC) begin
      n = $urandom_range(archive_bytes.size() - 1, 1);
      while (archive_bytes.size() > n) void'(archive_bytes.pop_back());
    end
  endtask

  // Send the built archive, one request per byte, with random sender gaps.
  task automatic send_archive();
    foreach (archive_bytes[k]) begin
      while ($urandom_range(99, 0) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid   <= 1'b1;
      byte_value <= archive_bytes[k][7:0];
      restart    <= archive_bytes[k][8];
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
    end
  endtask

  // Stop sending and let every predicted result drain, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers; the unused upper bits of max_entries get random data.
  task automatic set_config(input logic [31:0] fsize, input logic [19:0] max_ent);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FILE_SIZE;
    cfg_data  <= fsize;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MAX_ENTRIES;
    cfg_data  <= {12'($urandom), max_ent};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_file_size   = fsize;
    cur_max_entries = max_ent;
  endtask

  function automatic logic [31:0] choose_file_size();
    case ($urandom_range(9, 0))
      0:          return $urandom_range(32'h97, 0);
      1:          return 32'hFFFF_FFFF;
      2:          return MIN_FILE_SIZE;
      3:          return 32'h7FFF_FFFF;
      4, 5, 6:    return $urandom_range(32'h1000, 32'h98);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [19:0] choose_max_entries();
    case ($urandom_range(9, 0))
      0:       return 20'd0;
      1:       return 20'd1;
      2:       return MAX_ENTRIES_RESET;
      3:       return 20'hFFFFF;
      4:       return 20'd2;
      default: return 20'($urandom_range(20'hFFFFF, 3));
    endcase
  endfunction

  function automatic defect_t choose_defect();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return DF_NONE;
    if (r < 70) return DF_TRUNC;
    if (r < 75) return DF_NOISE;
    return defect_t'($urandom_range(DF_NONAME, DF_MAGIC));
  endfunction

  initial begin
    int unsigned mode_bytes, mode_results;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: a byte before any restart, then a restart with the reset file size.
    push_byte(8'($urandom_range(255, 0)), 1'b0);
    send_archive();
    build_archive(DF_NONE);
    send_archive();

    // Every kind of damage at the widest settings.
    wait_idle();
    set_config(32'hFFFF_FFFF, 20'hFFFFF);
    for (int f = DF_NONE; f <= DF_NOISE; f++) begin
      build_archive(defect_t'(f));
      send_archive();
    end

    // Smallest file that holds one entry, then one that is too small to fit two.
    wait_idle();
    set_config(MIN_FILE_SIZE, 20'd2);
    build_archive(DF_NONE);
    send_archive();
    build_archive(DF_DIRFIT);
    send_archive();

    // One byte below the minimum file size, and a zero entry limit.
    wait_idle();
    set_config(MIN_FILE_SIZE - 1, MAX_ENTRIES_RESET);
    build_archive(DF_NONE);
    send_archive();
    wait_idle();
    set_config(32'h1000, 20'd0);
    build_archive(DF_NONE);
    send_archive();

    // Random archives under three flow-control patterns.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 71 : 0;
      recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 33 : 0;
      mode_bytes    = bytes_sent;
      mode_results  = results_seen;
      while (bytes_sent - mode_bytes < 50 || results_seen - mode_results < 3) begin
        wait_idle();
        set_config(choose_file_size(), choose_max_entries());
        repeat (2) begin
          build_archive(choose_defect());
          send_archive();
          if ($urandom_range(9, 0) == 0) wait_idle();
        end
      end
    end

    wait_idle();
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
